@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the encoder RTL.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tce_pkg.sv @@
// Shared types, codes and tables of the Thrift encoder.
// Holds the control word layout, program addresses and entry decode; no dependencies.
`default_nettype none

package tce_pkg;

    // Request function codes
    localparam logic [3:0] FUNC_STOP   = 4'd0;
    localparam logic [3:0] FUNC_BYTE   = 4'd1;
    localparam logic [3:0] FUNC_BOOL   = 4'd2;
    localparam logic [3:0] FUNC_I16    = 4'd3;
    localparam logic [3:0] FUNC_I32    = 4'd4;
    localparam logic [3:0] FUNC_I64    = 4'd5;
    localparam logic [3:0] FUNC_VARINT = 4'd6;
    localparam logic [3:0] FUNC_FIELD  = 4'd7;
    localparam logic [3:0] FUNC_LIST   = 4'd8;
    localparam logic [3:0] FUNC_MAP    = 4'd9;
    localparam logic [3:0] FUNC_STRLEN = 4'd10;

    // Standard type code of bool
    localparam logic [3:0] TYPE_BOOL = 4'd2;

    // Compact constants
    localparam logic [3:0] NIB_TRUE     = 4'h1;
    localparam logic [3:0] NIB_FALSE    = 4'h2;
    localparam logic [3:0] NIB_LONG     = 4'hF;
    localparam logic [31:0] LIST_SHORT_MAX = 32'd14;

    localparam int PcW = 5;
    typedef logic [PcW-1:0] t_pc;

    // Byte source of a step
    typedef enum logic [3:0] {
        BS_NONE, BS_ZERO, BS_VALUE, BS_BOOL_BIN, BS_BOOL_CMP, BS_FTYPE, BS_VTYPE,
        BS_HELD, BS_FIELD_HDR, BS_LIST_HDR, BS_MAP_TYPES, BS_VARINT, BS_BE
    } t_bsrc;

    // Shift register load source
    typedef enum logic [3:0] {
        LS_NONE, LS_BE16, LS_BE32, LS_BE64, LS_BE_FID, LS_BE_SIZE, LS_ZZ16, LS_ZZ32,
        LS_ZZ64, LS_RAW, LS_SIZE, LS_ZZ_FID, LS_ZZ_HELD
    } t_lsrc;

    typedef enum logic [1:0] {LP_NONE, LP_VARINT, LP_BE} t_loop;

    typedef enum logic [2:0] {
        CD_TRUE, CD_HELD_SHORT, CD_FIELD_SHORT, CD_SIZE_LE14, CD_SIZE_ZERO
    } t_cond;

    typedef enum logic [1:0] {AC_NEXT, AC_END, AC_DISPATCH} t_act;

    // One control word of the program
    typedef struct packed {
        t_bsrc emit;
        t_lsrc load;
        t_loop loop;
        t_cond cond;
        t_act  on_true;
        t_act  on_false;
    } t_uword;

    typedef struct packed {
        t_pc   pc;
        t_lsrc load;
    } t_entry;

    // Sequencer to datapath
    typedef struct packed {
        logic  accept;
        logic  fire;
        logic  load_en;
        t_lsrc lsrc;
        logic  commit;
        t_bsrc emit;
        t_loop loop;
        t_cond cond;
    } t_dp_ctl;

    // Datapath to sequencer
    typedef struct packed {
        logic [7:0] out_byte;
        logic       stay;
        logic       cond_hit;
        logic       pending;
        t_entry     own;
    } t_dp_stat;

    // Program addresses
    localparam t_pc PC_HELD_GO     = t_pc'(0);
    localparam t_pc PC_HELD_GO_V   = t_pc'(1);
    localparam t_pc PC_HELD_END    = t_pc'(2);
    localparam t_pc PC_HELD_END_V  = t_pc'(3);
    localparam t_pc PC_EMPTY       = t_pc'(4);
    localparam t_pc PC_ZERO        = t_pc'(5);
    localparam t_pc PC_VALUE       = t_pc'(6);
    localparam t_pc PC_BOOL_BIN    = t_pc'(7);
    localparam t_pc PC_BOOL_CMP    = t_pc'(8);
    localparam t_pc PC_BIN_MAP     = t_pc'(9);
    localparam t_pc PC_BIN_MAP_V   = t_pc'(10);
    localparam t_pc PC_BE_END      = t_pc'(11);
    localparam t_pc PC_BIN_HDR     = t_pc'(12);
    localparam t_pc PC_BIN_HDR_BE  = t_pc'(13);
    localparam t_pc PC_VAR_END     = t_pc'(14);
    localparam t_pc PC_FIELD       = t_pc'(15);
    localparam t_pc PC_FIELD_V     = t_pc'(16);
    localparam t_pc PC_LIST        = t_pc'(17);
    localparam t_pc PC_LIST_V      = t_pc'(18);
    localparam t_pc PC_MAP         = t_pc'(19);
    localparam t_pc PC_MAP_TYPES   = t_pc'(20);
    localparam t_pc PC_LAST        = PC_MAP_TYPES;

    // Compact type nibble of a standard type code
    function automatic logic [3:0] ctype_of(input logic [3:0] code);
        logic [3:0] nib;
        case (code)
            4'd2:    nib = 4'd2;
            4'd3:    nib = 4'd3;
            4'd4:    nib = 4'd7;
            4'd6:    nib = 4'd4;
            4'd8:    nib = 4'd5;
            4'd10:   nib = 4'd6;
            4'd11:   nib = 4'd8;
            4'd12:   nib = 4'd12;
            4'd13:   nib = 4'd11;
            4'd14:   nib = 4'd10;
            4'd15:   nib = 4'd9;
            default: nib = 4'd0;
        endcase
        return nib;
    endfunction

    // Program entry and preload of a request's own bytes
    function automatic t_entry own_entry(input logic compact, input logic [3:0] func,
                                         input logic [3:0] ftype);
        t_entry e;
        e = '{pc: PC_EMPTY, load: LS_NONE};
        if (!compact) begin
            unique case (func)
                FUNC_STOP:   e = '{pc: PC_ZERO,     load: LS_NONE};
                FUNC_BYTE:   e = '{pc: PC_VALUE,    load: LS_NONE};
                FUNC_BOOL:   e = '{pc: PC_BOOL_BIN, load: LS_NONE};
                FUNC_I16:    e = '{pc: PC_BE_END,   load: LS_BE16};
                FUNC_I32:    e = '{pc: PC_BE_END,   load: LS_BE32};
                FUNC_I64:    e = '{pc: PC_BE_END,   load: LS_BE64};
                FUNC_FIELD:  e = '{pc: PC_BIN_HDR,  load: LS_BE_FID};
                FUNC_LIST:   e = '{pc: PC_BIN_HDR,  load: LS_BE_SIZE};
                FUNC_MAP:    e = '{pc: PC_BIN_MAP,  load: LS_BE_SIZE};
                FUNC_STRLEN: e = '{pc: PC_BE_END,   load: LS_BE_SIZE};
                default:     e = '{pc: PC_EMPTY,    load: LS_NONE};
            endcase
        end else begin
            unique case (func)
                FUNC_STOP:   e = '{pc: PC_ZERO,     load: LS_NONE};
                FUNC_BYTE:   e = '{pc: PC_VALUE,    load: LS_NONE};
                FUNC_BOOL:   e = '{pc: PC_BOOL_CMP, load: LS_NONE};
                FUNC_I16:    e = '{pc: PC_VAR_END,  load: LS_ZZ16};
                FUNC_I32:    e = '{pc: PC_VAR_END,  load: LS_ZZ32};
                FUNC_I64:    e = '{pc: PC_VAR_END,  load: LS_ZZ64};
                FUNC_VARINT: e = '{pc: PC_VAR_END,  load: LS_RAW};
                FUNC_FIELD:  e = (ftype == TYPE_BOOL) ? t_entry'{pc: PC_EMPTY, load: LS_NONE}
                                                      : t_entry'{pc: PC_FIELD, load: LS_NONE};
                FUNC_LIST:   e = '{pc: PC_LIST,     load: LS_NONE};
                FUNC_MAP:    e = '{pc: PC_MAP,      load: LS_SIZE};
                FUNC_STRLEN: e = '{pc: PC_VAR_END,  load: LS_SIZE};
                default:     e = '{pc: PC_EMPTY,    load: LS_NONE};
            endcase
        end
        return e;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tce_if.sv @@
// Handshake channels of the Thrift encoder: request, output byte and config write.
// Plain valid/ready interfaces; no package dependencies.
`default_nettype none

interface tce_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  func;
    logic signed [63:0] value;
    logic [3:0]  field_type;
    logic [3:0]  value_type;
    logic signed [15:0] field_id;

    modport source (output valid, func, value, field_type, value_type, field_id,
                    input ready);
    modport sink   (input valid, func, value, field_type, value_type, field_id,
                    output ready);
endinterface

interface tce_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

interface tce_cfg_if;
    logic valid;
    logic ready;
    logic compact_mode;

    modport source (output valid, compact_mode, input ready);
    modport sink   (input valid, compact_mode, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tce_ucode_rom.sv @@
// Control store of the encoder sequencer: one control word per program step.
// Depends on tce_pkg for the control word layout and program addresses.
`default_nettype none

module tce_ucode_rom
    import tce_pkg::*;
(
    input  t_pc    i_pc,
    output t_uword o_word
);

    function automatic t_uword uw(input t_bsrc e, input t_lsrc l, input t_loop lp,
                                  input t_cond c, input t_act t, input t_act f);
        return '{emit: e, load: l, loop: lp, cond: c, on_true: t, on_false: f};
    endfunction

    // Decode the step address into its control word
    always_comb begin
        unique case (i_pc)
            // Held bool header, then the request's own bytes
            PC_HELD_GO:    o_word = uw(BS_HELD, LS_ZZ_HELD, LP_NONE, CD_HELD_SHORT,
                                       AC_DISPATCH, AC_NEXT);
            PC_HELD_GO_V:  o_word = uw(BS_VARINT, LS_NONE, LP_VARINT, CD_TRUE,
                                       AC_DISPATCH, AC_DISPATCH);
            // Held bool header alone
            PC_HELD_END:   o_word = uw(BS_HELD, LS_ZZ_HELD, LP_NONE, CD_HELD_SHORT,
                                       AC_END, AC_NEXT);
            PC_HELD_END_V: o_word = uw(BS_VARINT, LS_NONE, LP_VARINT, CD_TRUE, AC_END, AC_END);
            PC_EMPTY:      o_word = uw(BS_NONE, LS_NONE, LP_NONE, CD_TRUE, AC_END, AC_END);
            PC_ZERO:       o_word = uw(BS_ZERO, LS_NONE, LP_NONE, CD_TRUE, AC_END, AC_END);
            PC_VALUE:      o_word = uw(BS_VALUE, LS_NONE, LP_NONE, CD_TRUE, AC_END, AC_END);
            PC_BOOL_BIN:   o_word = uw(BS_BOOL_BIN, LS_NONE, LP_NONE, CD_TRUE, AC_END, AC_END);
            PC_BOOL_CMP:   o_word = uw(BS_BOOL_CMP, LS_NONE, LP_NONE, CD_TRUE, AC_END, AC_END);
            // Binary map: key type, value type, size
            PC_BIN_MAP:    o_word = uw(BS_FTYPE, LS_NONE, LP_NONE, CD_TRUE, AC_NEXT, AC_NEXT);
            PC_BIN_MAP_V:  o_word = uw(BS_VTYPE, LS_NONE, LP_NONE, CD_TRUE, AC_NEXT, AC_NEXT);
            PC_BE_END:     o_word = uw(BS_BE, LS_NONE, LP_BE, CD_TRUE, AC_END, AC_END);
            // Binary field or list: type byte, then id or size
            PC_BIN_HDR:    o_word = uw(BS_FTYPE, LS_NONE, LP_NONE, CD_TRUE, AC_NEXT, AC_NEXT);
            PC_BIN_HDR_BE: o_word = uw(BS_BE, LS_NONE, LP_BE, CD_TRUE, AC_END, AC_END);
            PC_VAR_END:    o_word = uw(BS_VARINT, LS_NONE, LP_VARINT, CD_TRUE, AC_END, AC_END);
            // Compact field: short form ends, long form adds the zigzag id
            PC_FIELD:      o_word = uw(BS_FIELD_HDR, LS_ZZ_FID, LP_NONE, CD_FIELD_SHORT,
                                       AC_END, AC_NEXT);
            PC_FIELD_V:    o_word = uw(BS_VARINT, LS_NONE, LP_VARINT, CD_TRUE, AC_END, AC_END);
            // Compact list: short form ends, long form adds the size
            PC_LIST:       o_word = uw(BS_LIST_HDR, LS_SIZE, LP_NONE, CD_SIZE_LE14,
                                       AC_END, AC_NEXT);
            PC_LIST_V:     o_word = uw(BS_VARINT, LS_NONE, LP_VARINT, CD_TRUE, AC_END, AC_END);
            // Compact map: size varint (a lone zero when empty), then the types
            PC_MAP:        o_word = uw(BS_VARINT, LS_NONE, LP_VARINT, CD_SIZE_ZERO,
                                       AC_END, AC_NEXT);
            PC_MAP_TYPES:  o_word = uw(BS_MAP_TYPES, LS_NONE, LP_NONE, CD_TRUE, AC_END, AC_END);
            default:       o_word = uw(BS_NONE, LS_NONE, LP_NONE, CD_TRUE, AC_END, AC_END);
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/tce_datapath.sv @@
// Datapath of the encoder: request latch, shift register, byte select and held header.
// Depends on tce_pkg; driven step by step by the sequencer in the top level.
`default_nettype none

module tce_datapath
    import tce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_compact,
    input  logic [3:0]  i_func,
    input  logic [63:0] i_value,
    input  logic [3:0]  i_field_type,
    input  logic [3:0]  i_value_type,
    input  logic [15:0] i_field_id,
    input  t_dp_ctl     i_ctl,
    output t_dp_stat    o_stat
);

    `include "assert_macros.svh"

    // Latched request
    logic [3:0]  r_func;
    logic [63:0] r_value;
    logic [3:0]  r_ftype;
    logic [3:0]  r_vtype;
    logic [15:0] r_fid;
    logic [3:0]  r_delta;

    // Emission shift register and byte count
    logic [63:0] r_sh;
    logic [3:0]  r_cnt;

    // Persistent encoder state
    logic [15:0] r_prev, n_prev;
    logic        r_pending, n_pending;
    logic [15:0] r_held_id, n_held_id;
    logic [3:0]  r_held_delta, n_held_delta;

    logic [63:0] src_value;
    logic [15:0] src_fid;
    logic [31:0] src_size;
    logic [63:0] ld_sh;
    logic [3:0]  ld_cnt;
    logic [16:0] id_diff;
    logic [3:0]  in_delta;
    logic        more;
    logic [31:0] r_size;
    logic [3:0]  ct_f;
    logic [3:0]  ct_v;
    logic [3:0]  held_nib;
    logic        set_hold;
    logic [7:0]  sel_byte;

    function automatic logic [31:0] zz16(input logic [15:0] x);
        logic [31:0] s;
        s = {{16{x[15]}}, x};
        return {s[30:0], 1'b0} ^ {32{s[31]}};
    endfunction

    function automatic logic [31:0] zz32(input logic [31:0] u);
        return {u[30:0], 1'b0} ^ {32{u[31]}};
    endfunction

    // Pick load operands: request ports on accept, latched request afterwards
    always_comb begin
        src_value = i_ctl.accept ? i_value : r_value;
        src_fid   = i_ctl.accept ? i_field_id : r_fid;
        src_size  = src_value[31:0];
    end

    // Shift register load value and byte count
    always_comb begin
        ld_sh  = 64'h0;
        ld_cnt = 4'd1;
        case (i_ctl.lsrc)
            LS_BE16:    begin ld_sh = {src_value[15:0], 48'h0}; ld_cnt = 4'd2; end
            LS_BE32:    begin ld_sh = {src_value[31:0], 32'h0}; ld_cnt = 4'd4; end
            LS_BE64:    begin ld_sh = src_value;                ld_cnt = 4'd8; end
            LS_BE_FID:  begin ld_sh = {src_fid, 48'h0};         ld_cnt = 4'd2; end
            LS_BE_SIZE: begin ld_sh = {src_size, 32'h0};        ld_cnt = 4'd4; end
            LS_ZZ16:    ld_sh = {32'h0, zz16(src_value[15:0])};
            LS_ZZ32:    ld_sh = {32'h0, zz32(src_size)};
            LS_ZZ64:    ld_sh = {src_value[62:0], 1'b0} ^ {64{src_value[63]}};
            LS_RAW:     ld_sh = src_value;
            LS_SIZE:    ld_sh = {32'h0, src_size};
            LS_ZZ_FID:  ld_sh = {32'h0, zz16(src_fid)};
            LS_ZZ_HELD: ld_sh = {32'h0, zz16(r_held_id)};
            default:    ld_sh = 64'h0;
        endcase
    end

    // Field id delta against the previous id, zero selects the long form
    always_comb begin
        id_diff  = {i_field_id[15], i_field_id} - {r_prev[15], r_prev};
        in_delta = (!id_diff[16] && id_diff[15:4] == 12'h0) ? id_diff[3:0] : 4'h0;
    end

    // Select the outgoing byte
    always_comb begin
        more     = |r_sh[63:7];
        r_size   = r_value[31:0];
        ct_f     = ctype_of(r_ftype);
        ct_v     = ctype_of(r_vtype);
        held_nib = (i_compact && r_func == FUNC_BOOL && r_value != 64'h0) ? NIB_TRUE
                                                                           : NIB_FALSE;
        sel_byte = 8'h00;
        case (i_ctl.emit)
            BS_VALUE:     sel_byte = r_value[7:0];
            BS_BOOL_BIN:  sel_byte = {7'h0, r_value != 64'h0};
            BS_BOOL_CMP:  sel_byte = {4'h0, (r_value != 64'h0) ? NIB_TRUE : NIB_FALSE};
            BS_FTYPE:     sel_byte = {4'h0, r_ftype};
            BS_VTYPE:     sel_byte = {4'h0, r_vtype};
            BS_HELD:      sel_byte = {r_held_delta, held_nib};
            BS_FIELD_HDR: sel_byte = {r_delta, ct_f};
            BS_LIST_HDR:  sel_byte = (r_size <= LIST_SHORT_MAX)
                                     ? {r_size[3:0], ct_f} : {NIB_LONG, ct_f};
            BS_MAP_TYPES: sel_byte = {ct_f, ct_v};
            BS_VARINT:    sel_byte = {more, r_sh[6:0]};
            BS_BE:        sel_byte = r_sh[63:56];
            default:      sel_byte = 8'h00;
        endcase
    end

    // Loop and branch status for the sequencer
    always_comb begin
        o_stat.out_byte = sel_byte;
        case (i_ctl.loop)
            LP_VARINT: o_stat.stay = more;
            LP_BE:     o_stat.stay = (r_cnt != 4'd1);
            default:   o_stat.stay = 1'b0;
        endcase
        case (i_ctl.cond)
            CD_HELD_SHORT:  o_stat.cond_hit = (r_held_delta != 4'h0);
            CD_FIELD_SHORT: o_stat.cond_hit = (r_delta != 4'h0);
            CD_SIZE_LE14:   o_stat.cond_hit = (r_size <= LIST_SHORT_MAX);
            CD_SIZE_ZERO:   o_stat.cond_hit = (r_size == 32'h0);
            default:        o_stat.cond_hit = 1'b1;
        endcase
        o_stat.pending = r_pending;
        o_stat.own     = own_entry(i_compact, r_func, r_ftype);
    end

    // Next encoder state: id on accept, held header on completion
    always_comb begin
        n_prev       = r_prev;
        n_pending    = r_pending;
        n_held_id    = r_held_id;
        n_held_delta = r_held_delta;
        set_hold     = i_compact && r_func == FUNC_FIELD && r_ftype == TYPE_BOOL;
        if (i_ctl.accept && i_compact && i_func == FUNC_FIELD) begin
            n_prev = i_field_id;
        end
        if (i_ctl.commit && r_func <= FUNC_STRLEN) begin
            n_pending = set_hold;
            if (set_hold) begin
                n_held_id    = r_fid;
                n_held_delta = r_delta;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= 16'h0;
            r_pending    <= 1'b0;
            r_held_id    <= 16'h0;
            r_held_delta <= 4'h0;
        end else begin
            r_prev       <= n_prev;
            r_pending    <= n_pending;
            r_held_id    <= n_held_id;
            r_held_delta <= n_held_delta;
        end
    end

    // Latch the request and advance the shift register
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_func  <= i_func;
            r_value <= i_value;
            r_ftype <= i_field_type;
            r_vtype <= i_value_type;
            r_fid   <= i_field_id;
            r_delta <= in_delta;
        end
        if (i_ctl.load_en) begin
            r_sh  <= ld_sh;
            r_cnt <= ld_cnt;
        end else if (i_ctl.fire) begin
            case (i_ctl.loop)
                LP_VARINT: r_sh <= {7'h0, r_sh[63:7]};
                LP_BE: begin
                    r_sh  <= {r_sh[55:0], 8'h0};
                    r_cnt <= r_cnt - 4'd1;
                end
                default: r_sh <= r_sh;
            endcase
        end
    end

    `ASSERT_IMPLY(a_hold_matches_prev, i_clk, i_rst_n, $rose(r_pending), r_prev == r_held_id, "held header id differs from last field id")
    `ASSERT_IMPLY(a_be_count_live, i_clk, i_rst_n, i_ctl.fire && i_ctl.loop == LP_BE, r_cnt != 4'd0, "big-endian step with empty byte count")

endmodule

`default_nettype wire

@@ hw/rtl/thrift_compact_encoder.sv @@
// Top level of the Thrift serializer: sequencer, output register and mode register.
// Depends on tce_pkg, tce_if, tce_ucode_rom and tce_datapath.
//
// Usage:
//   i_req  takes one write request (func, value, field_type, value_type, field_id).
//   o_out  returns the serialized bytes in stream order; last marks the final
//          byte caused by a request. A request may cause no bytes at all.
//   i_cfg  writes compact_mode (1 compact form, 0 big-endian binary form);
//          it is always ready and should be written only while idle.
// Timing:
//   A request is taken when the block is idle. A microcode program then runs
//   one step per cycle while no emitting step waits on the output, one output
//   byte per emitting step; the step counter loops on a step while a varint or
//   big-endian field has bytes left. The request channel stays not ready until
//   the program ends, so the next request is taken only once the block is idle.
//   The first byte enters the output register when the first emitting step fires.
// Reset and stalls:
//   Reset selects compact mode, clears the field id history and drops any
//   held bool header. While o_out.ready is low and the output register holds
//   a byte, an emitting step waits; the byte stays and none is lost or repeated.
`default_nettype none

module thrift_compact_encoder
    import tce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    tce_req_if.sink           i_req,
    tce_byte_if.source        o_out,
    tce_cfg_if.sink           i_cfg
);

    `include "assert_macros.svh"

    typedef enum logic {ST_IDLE, ST_RUN} t_seq_state;

    t_seq_state r_state, n_state;
    t_pc        r_pc, n_pc;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;
    logic       r_compact;

    t_uword   uword;
    t_dp_ctl  ctl;
    t_dp_stat stat;
    t_entry   own_in;
    t_entry   start;
    t_act     act;
    logic     out_free;
    logic     needs_out;
    logic     fire;
    logic     complete;
    logic     accept;
    logic     func_ok;
    logic     consume;

    tce_ucode_rom u_rom (
        .i_pc   (r_pc),
        .o_word (uword)
    );

    tce_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_compact    (r_compact),
        .i_func       (i_req.func),
        .i_value      (i_req.value),
        .i_field_type (i_req.field_type),
        .i_value_type (i_req.value_type),
        .i_field_id   (i_req.field_id),
        .i_ctl        (ctl),
        .o_stat       (stat)
    );

    // Mode register write port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compact <= 1'b1;
        end else if (i_cfg.valid) begin
            r_compact <= i_cfg.compact_mode;
        end
    end

    // Handshakes and step execution
    always_comb begin
        out_free  = !r_out_valid || o_out.ready;
        needs_out = (uword.emit != BS_NONE);
        fire      = (r_state == ST_RUN) && (!needs_out || out_free);
        complete  = fire && !stat.stay;
        act       = stat.cond_hit ? uword.on_true : uword.on_false;
        accept    = i_req.valid && (r_state == ST_IDLE);
    end

    // Program entry for a new request: flush a held header first
    always_comb begin
        own_in  = own_entry(r_compact, i_req.func, i_req.field_type);
        func_ok = (i_req.func <= FUNC_STRLEN);
        consume = r_compact && (i_req.func == FUNC_BOOL);
        if (func_ok && stat.pending) begin
            start.pc   = (consume || own_in.pc == PC_EMPTY) ? PC_HELD_END : PC_HELD_GO;
            start.load = LS_NONE;
        end else begin
            start = own_in;
        end
    end

    // Drive the datapath
    always_comb begin
        ctl.accept = accept;
        ctl.fire   = fire;
        ctl.emit   = uword.emit;
        ctl.loop   = uword.loop;
        ctl.cond   = uword.cond;
        ctl.commit = complete && (act == AC_END);
        if (accept) begin
            ctl.lsrc = start.load;
        end else if (complete && act == AC_DISPATCH) begin
            ctl.lsrc = stat.own.load;
        end else if (complete) begin
            ctl.lsrc = uword.load;
        end else begin
            ctl.lsrc = LS_NONE;
        end
        ctl.load_en = (ctl.lsrc != LS_NONE);
    end

    // Step counter, jumps and output register
    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (accept) begin
            n_state = ST_RUN;
            n_pc    = start.pc;
        end else if (complete) begin
            unique case (act)
                AC_NEXT:     n_pc = r_pc + t_pc'(1);
                AC_DISPATCH: n_pc = stat.own.pc;
                AC_END:      n_state = ST_IDLE;
                default:     n_state = ST_IDLE;
            endcase
        end
        if (fire && needs_out) begin
            n_out_valid = 1'b1;
            n_out_byte  = stat.out_byte;
            n_out_last  = complete && (act == AC_END);
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= PC_EMPTY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign i_req.ready    = (r_state == ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;

    `ASSERT_IMPLY(a_pc_in_program, i_clk, i_rst_n, r_state == ST_RUN, r_pc <= PC_LAST, "step counter outside program")
    `ASSERT_IMPLY(a_dispatch_from_held, i_clk, i_rst_n, complete && act == AC_DISPATCH, (r_pc == PC_HELD_GO) || (r_pc == PC_HELD_GO_V), "dispatch outside held header program")
    `ASSERT_NEXT(a_last_ends_item, i_clk, i_rst_n, fire && needs_out && complete && act == AC_END, (r_state == ST_IDLE) && r_out_valid && r_out_last, "final byte without returning to idle")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench of thrift_compact_encoder: directed and random requests in both modes.
// Depends on tce_pkg, tce_if and the encoder RTL; predicts every output word in the bench.
`default_nettype none

module testbench;
    import tce_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 16;

    localparam logic [3:0] FUNC_RESERVED_LOW = 4'd11;
    localparam logic [3:0] FUNC_RESERVED_TOP = 4'd15;

    // Compact type nibble per standard type code, code 0 in the low nibble
    localparam logic [63:0] NIBBLE_TABLE = 64'h9ABC_8605_0407_3200;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tce_req_if  req_ch();
    tce_byte_if out_ch();
    tce_cfg_if  cfg_ch();

    thrift_compact_encoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Encoder state as the predictor tracks it
    logic        mode_compact;
    logic [15:0] last_field_id;
    logic        bool_held;
    logic [15:0] held_id;
    logic [3:0]  held_delta;

    t_out_word   expected_words[$];
    logic [7:0]  item_words[$];

    int error_count   = 0;
    int requests_sent = 0;
    int words_taken   = 0;
    int quiet_cycles  = 0;
    bit sender_idle   = 1'b1;
    bit sink_idle     = 1'b1;

    // Run the clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // ---------------- prediction ----------------

    function automatic logic [3:0] compact_nibble(input logic [3:0] code);
        return NIBBLE_TABLE[4*code +: 4];
    endfunction

    function automatic logic [31:0] zigzag32(input logic [31:0] u);
        return {u[30:0], 1'b0} ^ {32{u[31]}};
    endfunction

    function automatic logic [63:0] zigzag64(input logic [63:0] u);
        return {u[62:0], 1'b0} ^ {64{u[63]}};
    endfunction

    function automatic void put_word(input logic [7:0] b);
        item_words.push_back(b);
    endfunction

    // Append the low nbytes of v, most significant first
    function automatic void put_be(input logic [63:0] v, input int nbytes);
        int i;
        for (i = nbytes - 1; i >= 0; i--) begin
            put_word(8'(v >> (8 * i)));
        end
    endfunction

    // Append v as base-128 groups, low group first
    function automatic void put_varint(input logic [63:0] v);
        logic done;
        do begin
            done = (v >> 7) == 64'd0;
            put_word(done ? v[7:0] : {1'b1, v[6:0]});
            v = v >> 7;
        end while (!done);
    endfunction

    // Release the held bool field header with the given value nibble
    function automatic void emit_held(input logic [3:0] nib);
        if (held_delta != 4'd0) begin
            put_word({held_delta, nib});
        end else begin
            put_word({4'h0, nib});
            put_varint(64'(zigzag32({{16{held_id[15]}}, held_id})));
        end
        bool_held = 1'b0;
    endfunction

    function automatic void predict_request(input logic [3:0] func, input logic [63:0] value,
                                            input logic [3:0] ftype, input logic [3:0] vtype,
                                            input logic [15:0] fid);
        logic [31:0] size;
        logic [3:0]  nib;
        logic [3:0]  delta;
        int          id_now;
        int          id_prev;
        size = value[31:0];
        nib  = compact_nibble(ftype);
        item_words.delete();
        if (func > FUNC_STRLEN) begin
            return;
        end
        if (bool_held && mode_compact && func == FUNC_BOOL) begin
            emit_held(value != 64'd0 ? NIB_TRUE : NIB_FALSE);
        end else begin
            // any other request flushes a held header as false
            if (bool_held) begin
                emit_held(NIB_FALSE);
            end
            if (!mode_compact) begin
                case (func)
                    FUNC_STOP:   put_word(8'h00);
                    FUNC_BYTE:   put_word(value[7:0]);
                    FUNC_BOOL:   put_word(value != 64'd0 ? 8'h01 : 8'h00);
                    FUNC_I16:    put_be(value, 2);
                    FUNC_I32:    put_be(value, 4);
                    FUNC_I64:    put_be(value, 8);
                    FUNC_FIELD: begin
                        put_word({4'h0, ftype});
                        put_be(64'(fid), 2);
                    end
                    FUNC_LIST: begin
                        put_word({4'h0, ftype});
                        put_be(64'(size), 4);
                    end
                    FUNC_MAP: begin
                        put_word({4'h0, ftype});
                        put_word({4'h0, vtype});
                        put_be(64'(size), 4);
                    end
                    FUNC_STRLEN: put_be(64'(size), 4);
                    default: ;
                endcase
            end else begin
                case (func)
                    FUNC_STOP:   put_word(8'h00);
                    FUNC_BYTE:   put_word(value[7:0]);
                    FUNC_BOOL:   put_word({4'h0, value != 64'd0 ? NIB_TRUE : NIB_FALSE});
                    FUNC_I16:    put_varint(64'(zigzag32({{16{value[15]}}, value[15:0]})));
                    FUNC_I32:    put_varint(64'(zigzag32(size)));
                    FUNC_I64:    put_varint(zigzag64(value));
                    FUNC_VARINT: put_varint(value);
                    FUNC_FIELD: begin
                        id_now  = $signed(fid);
                        id_prev = $signed(last_field_id);
                        delta   = (id_now > id_prev && id_now - id_prev <= 15)
                                ? 4'(id_now - id_prev) : 4'd0;
                        if (ftype == TYPE_BOOL) begin
                            bool_held  = 1'b1;
                            held_id    = fid;
                            held_delta = delta;
                        end else if (delta != 4'd0) begin
                            put_word({delta, nib});
                        end else begin
                            put_word({4'h0, nib});
                            put_varint(64'(zigzag32({{16{fid[15]}}, fid})));
                        end
                        last_field_id = fid;
                    end
                    FUNC_LIST: begin
                        if (size <= LIST_SHORT_MAX) begin
                            put_word({size[3:0], nib});
                        end else begin
                            put_word({NIB_LONG, nib});
                            put_varint(64'(size));
                        end
                    end
                    FUNC_MAP: begin
                        if (size == 32'd0) begin
                            put_word(8'h00);
                        end else begin
                            put_varint(64'(size));
                            put_word({nib, compact_nibble(vtype)});
                        end
                    end
                    default: put_varint(64'(size));
                endcase
            end
        end
        foreach (item_words[i]) begin
            expected_words.push_back({item_words[i], i == item_words.size() - 1});
        end
    endfunction

    // ---------------- stimulus ----------------

    // Send one request word, after a random gap while sender_idle is set, and predict its output
    task automatic send_request(input logic [3:0] func, input logic [63:0] value,
                                input logic [3:0] ftype, input logic [3:0] vtype,
                                input logic [15:0] fid);
        int gap;
        gap = sender_idle ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= func;
        req_ch.value      <= value;
        req_ch.field_type <= ftype;
        req_ch.value_type <= vtype;
        req_ch.field_id   <= fid;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        predict_request(func, value, ftype, vtype, fid);
        if (func <= FUNC_STRLEN) begin
            requests_sent++;
        end
    endtask

    // Drop valid and hold until every expected word is out and the block settles
    task automatic wait_idle();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic compact);
        @(negedge i_clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.compact_mode <= compact;
        do begin
            @(posedge i_clk);
        end while (!cfg_ch.ready);
        mode_compact = compact;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand_value();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 6))
            0:       return 64'($urandom_range(0, 20));
            1:       return 64'($urandom_range(0, 400));
            2:       return {w, 32'($urandom)};
            3:       return -64'($urandom_range(1, 400));
            4:       return {{32{w[31]}}, w};
            5:       return {w[0], {63{w[1]}}};   // min, max, zero or all ones
            default: return {w, 27'd0, 5'($urandom_range(0, 20))};
        endcase
    endfunction

    // Field ids mostly a short step ahead so both header forms show up
    function automatic logic [15:0] next_field_id();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom);
            1:       return last_field_id - 16'($urandom_range(0, 3));
            default: return last_field_id + 16'($urandom_range(1, 15));
        endcase
    endfunction

    task automatic send_with_noise(input logic [3:0] func);
        logic [63:0] value;
        value = (func == FUNC_BOOL && $urandom_range(0, 1) == 1) ? 64'd0 : rand_value();
        send_request(func, value, 4'($urandom), 4'($urandom), 16'($urandom));
    endtask

    // ---------------- tests ----------------

    task automatic test_compact_directed();
        write_mode(1'b1);
        send_request(FUNC_FIELD, rand_value(), 4'd8, 4'($urandom), 16'd1);
        send_request(FUNC_I32, {32'($urandom), 32'h8000_0000}, 4'd0, 4'd0, 16'd0);
        // bool header held, then released by a true bool
        send_request(FUNC_FIELD, rand_value(), TYPE_BOOL, 4'($urandom), 16'd2);
        send_request(FUNC_BOOL, 64'h100, 4'($urandom), 4'($urandom), 16'($urandom));
        send_request(FUNC_FIELD, rand_value(), 4'd10, 4'($urandom), 16'h7FFF);
        send_request(FUNC_I64, 64'h8000_0000_0000_0000, 4'd0, 4'd0, 16'd0);
        send_request(FUNC_I16, {32'($urandom), 16'($urandom), 16'h8000}, 4'd0, 4'd0, 16'd0);
        send_request(FUNC_VARINT, '1, 4'($urandom), 4'($urandom), 16'($urandom));
        // long-form bool header flushed as false by a byte
        send_request(FUNC_FIELD, rand_value(), TYPE_BOOL, 4'($urandom), 16'h8000);
        send_request(FUNC_BYTE, {32'($urandom), 24'($urandom), 8'hFF}, 4'd0, 4'd0, 16'd0);
        send_request(FUNC_LIST, 64'd14, 4'd15, 4'($urandom), 16'($urandom));
        send_request(FUNC_LIST, 64'd15, 4'd12, 4'($urandom), 16'($urandom));
        send_request(FUNC_MAP, {32'($urandom), 32'd0}, 4'($urandom), 4'($urandom), 16'd0);
        send_request(FUNC_MAP, '1, 4'd11, 4'd15, 16'($urandom));
        send_request(FUNC_STRLEN, 64'd300, 4'($urandom), 4'($urandom), 16'($urandom));
        send_request(FUNC_RESERVED_TOP, rand_value(), 4'($urandom), 4'($urandom), 16'($urandom));
        send_request(FUNC_STOP, 64'd0, 4'd0, 4'd0, 16'd0);
        // leave a header held across the switch to binary mode
        send_request(FUNC_FIELD, rand_value(), TYPE_BOOL, 4'($urandom), 16'd3);
    endtask

    task automatic test_binary_directed();
        wait_idle();
        write_mode(1'b0);
        send_request(FUNC_I32, rand_value(), 4'($urandom), 4'($urandom), 16'($urandom));
        send_request(FUNC_BOOL, 64'h8000_0000_0000_0000, 4'd0, 4'd0, 16'd0);
        send_request(FUNC_I64, 64'h7FFF_FFFF_FFFF_FFFF, 4'd0, 4'd0, 16'd0);
        send_request(FUNC_VARINT, rand_value(), 4'($urandom), 4'($urandom), 16'($urandom));
        send_request(FUNC_FIELD, rand_value(), TYPE_BOOL, 4'($urandom), 16'hFFFF);
        send_request(FUNC_LIST, rand_value(), 4'($urandom), 4'($urandom), 16'($urandom));
        send_request(FUNC_MAP, rand_value(), 4'($urandom), 4'($urandom), 16'($urandom));
        send_request(FUNC_STRLEN, rand_value(), 4'($urandom), 4'($urandom), 16'($urandom));
        send_request(FUNC_RESERVED_LOW, rand_value(), 4'($urandom), 4'($urandom), 16'($urandom));
    endtask

    // Mostly field header plus value pairs, bool header chains and some noise
    task automatic test_random_traffic(input logic compact, input int count);
        int          first;
        bit          paused;
        logic [15:0] id;
        wait_idle();
        write_mode(compact);
        first  = requests_sent;
        paused = 1'b0;
        while (requests_sent - first < count) begin
            if ($urandom_range(0, 11) == 0) begin
                sender_idle = $urandom_range(0, 2) != 0;
                sink_idle   = $urandom_range(0, 2) != 0;
            end
            if (!paused && requests_sent - first >= count / 2) begin
                wait_idle();
                paused = 1'b1;
            end
            id = next_field_id();
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    send_request(FUNC_FIELD, rand_value(), 4'($urandom), 4'($urandom), id);
                    send_with_noise(4'($urandom_range(1, 10)));
                end
                4, 5: begin
                    send_request(FUNC_FIELD, rand_value(), TYPE_BOOL, 4'($urandom), id);
                    if ($urandom_range(0, 9) != 0) begin
                        send_with_noise(FUNC_BOOL);
                    end else begin
                        send_with_noise(4'($urandom_range(0, 10)));
                    end
                end
                6: begin
                    send_request(FUNC_FIELD, rand_value(), TYPE_BOOL, 4'($urandom), id);
                    send_request(FUNC_FIELD, rand_value(), TYPE_BOOL, 4'($urandom),
                                 next_field_id());
                    send_with_noise(FUNC_BOOL);
                end
                7, 8: send_with_noise(4'($urandom_range(0, 10)));
                default: send_with_noise(4'($urandom_range(0, 15)));
            endcase
        end
    endtask

    // ---------------- output side ----------------

    // Drive ready; while sink_idle is set, stall a random number of cycles after each word taken
    initial begin : output_stall
        int seen;
        int hold;
        seen = 0;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (words_taken != seen) begin
                seen = words_taken;
                hold = sink_idle ? $urandom_range(0, 7) : 0;
            end
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Check each output word against the oldest expected word
    always @(posedge i_clk) begin : output_check
        t_out_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            words_taken++;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("word %02h last %0b with nothing expected",
                                          out_ch.out_byte, out_ch.last));
            end else begin
                want = expected_words.pop_front();
                if (out_ch.out_byte !== want.data) begin
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_ch.out_byte, want.data));
                end
                if (out_ch.last !== want.last) begin
                    report_mismatch($sformatf("last %0b, expected %0b on word %02h",
                                              out_ch.last, want.last, want.data));
                end
            end
        end
    end

    // End the run when no word moves on any channel for too long
    always @(posedge i_clk) begin : watchdog
        if ((req_ch.valid && req_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        req_ch.valid        <= 1'b0;
        req_ch.func         <= FUNC_STOP;
        req_ch.value        <= '0;
        req_ch.field_type   <= '0;
        req_ch.value_type   <= '0;
        req_ch.field_id     <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.compact_mode <= 1'b1;
        i_rst_n             <= 1'b0;
        mode_compact  = 1'b1;
        last_field_id = '0;
        bool_held     = 1'b0;
        held_id       = '0;
        held_delta    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_compact_directed();
        test_binary_directed();
        test_random_traffic(1'b1, 80);
        test_random_traffic(1'b0, 80);
        test_random_traffic(1'b1, 80);
        wait_idle();

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/tce_pkg.sv
hw/rtl/tce_if.sv
hw/rtl/tce_ucode_rom.sv
hw/rtl/tce_datapath.sv
hw/rtl/thrift_compact_encoder.sv
dv/testbench.sv
